[design/weighted_histogram_accumulator_macros.svh]
// Assertion macros shared by the checker of the weighted histogram accumulator.
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_MACROS_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define WHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that an antecedent implies a consequent in the following cycle.
`define WHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/wha_pkg.sv]
// ----------------------------------------------------------------------------
// Weighted histogram package
// Shared types, command codes and constants of the weighted histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package wha_pkg;

    localparam int unsigned MAX_BINS_DEF = 256;

    typedef enum logic [1:0] {
        CMD_FILL  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_RANGE_LOW = 2'd0,
        REG_BIN_SCALE = 2'd1,
        REG_NUM_BINS  = 2'd2
    } reg_idx_t;

    localparam logic [47:0] WS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] WS_MIN = 48'h8000_0000_0000;
    localparam logic [62:0] SQ_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the transaction
        logic mul;       // register the scaled product
        logic pick;      // choose the bin and issue the read
        logic rd_wait;   // memory data arrives
        logic update;    // form new sums and write back
        logic sqrt_go;   // start the square root
        logic sqrt_step; // one square-root step
        logic clr_step;  // clear one bin
        logic emit;      // drive the result
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_done;
        logic clr_done;
    } stat_t;

endpackage

`default_nettype wire

[design/wha_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-before-write port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[design/wha_ctrl.sv]
// ----------------------------------------------------------------------------
// Weighted histogram controller
// Sequences each transaction through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wha_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     command,
    input  wha_pkg::stat_t      stat,
    output logic                busy,
    output wha_pkg::ctrl_t      ctrl,
    output logic                done
);
    import wha_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL   = 9'b000000010,
        S_PICK  = 9'b000000100,
        S_RDW   = 9'b000001000,
        S_UPD   = 9'b000010000,
        S_SQRT  = 9'b000100000,
        S_CLR   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_RDPK  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   init_reg, init_next;

    // Next state. The sweep straight after reset zeroes the bins and emits
    // no result.
    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    case (command)
                        CMD_FILL:  state_next = S_MUL;
                        CMD_READ:  state_next = S_RDPK;
                        CMD_CLEAR: state_next = S_CLR;
                        default:   state_next = S_EMIT;
                    endcase
                end
            end
            S_MUL:
            begin
                ctrl.mul   = 1'b1;
                state_next = S_PICK;
            end
            S_PICK, S_RDPK:
            begin
                ctrl.pick  = 1'b1;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                ctrl.rd_wait = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                ctrl.update  = 1'b1;
                ctrl.sqrt_go = 1'b1;
                state_next   = S_SQRT;
            end
            S_SQRT:
            begin
                ctrl.sqrt_step = 1'b1;
                if (stat.sqrt_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_CLR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = init_reg ? S_IDLE : S_EMIT;
                    init_next  = 1'b0;
                end
            end
            S_EMIT:
            begin
                ctrl.emit  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_EMIT);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
        end
    end

endmodule

`default_nettype wire

[design/wha_dp.sv]
// ----------------------------------------------------------------------------
// Weighted histogram datapath
// Bin selection, bin memories, saturating sums, square root and clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module wha_dp #(
    parameter int unsigned MAX_BINS = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wha_pkg::ctrl_t      ctrl,
    output wha_pkg::stat_t      stat,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic [1:0]     command,
    input  wire logic [31:0]    sample,
    input  wire logic [15:0]    weight,
    input  wire logic [8:0]     bin_select,
    output logic      [8:0]     bin_index,
    output logic      [47:0]    weight_sum,
    output logic      [31:0]    error_estimate,
    output logic      [31:0]    entry_count,
    output logic                status
);
    import wha_pkg::*;

    localparam int unsigned SLOTS = MAX_BINS + 2;
    localparam int unsigned AW    = $clog2(SLOTS);

    // Configuration registers.
    logic [31:0] range_low_reg, bin_scale_reg;
    logic [8:0]  num_bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg <= '0;
            bin_scale_reg <= 32'd65536;
            num_bins_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LOW: range_low_reg <= cfg_data;
                REG_BIN_SCALE: bin_scale_reg <= cfg_data;
                REG_NUM_BINS:  num_bins_reg  <= cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    // Effective bin count, clamped to one..MAX_BINS.
    logic [12:0] eff_bins;
    always_comb
    begin
        if (num_bins_reg == '0)
        begin
            eff_bins = 13'd1;
        end
        else if (13'(num_bins_reg) > 13'(MAX_BINS))
        begin
            eff_bins = 13'(MAX_BINS);
        end
        else
        begin
            eff_bins = 13'(num_bins_reg);
        end
    end

    // Transaction capture; the difference magnitude is taken at once.
    logic [1:0]  cmd_reg;
    logic [15:0] w_reg;
    logic [8:0]  sel_reg;
    logic [32:0] mag_reg;
    logic        neg_reg;
    logic [32:0] diff;

    assign diff = {sample[31], sample} - {range_low_reg[31], range_low_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            w_reg   <= weight;
            sel_reg <= bin_select;
            neg_reg <= diff[32];
            mag_reg <= diff[32] ? (33'd0 - diff) : diff;
        end
    end

    // Product, high part only; the magnitude is at most 2^32, so the product
    // stays below 2^64.
    logic [31:0] q_reg;
    logic [63:0] prod;
    assign prod = 64'(mag_reg) * 64'(bin_scale_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            q_reg <= prod[63:32];
        end
    end

    // Bin choice and validity.
    logic [AW-1:0] addr_reg;
    logic [8:0]    idx_reg;
    logic          bad_reg;
    logic [8:0]    pick_idx;
    logic          pick_bad;

    always_comb
    begin
        pick_bad = 1'b0;
        if (cmd_reg == CMD_FILL)
        begin
            if (neg_reg)
            begin
                pick_idx = (q_reg != '0) ? 9'd0 : 9'd1;
            end
            else if (q_reg >= 32'(eff_bins))
            begin
                pick_idx = 9'(eff_bins + 13'd1);
            end
            else
            begin
                pick_idx = q_reg[8:0] + 9'd1;
            end
        end
        else
        begin
            pick_idx = sel_reg;
            pick_bad = (13'(sel_reg) >= eff_bins + 13'd2);
        end
    end

    // Clear sweep counter.
    logic [AW-1:0] clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctrl.clr_step)
        begin
            clr_reg <= stat.clr_done ? '0 : clr_reg + 1'b1;
        end
    end
    assign stat.clr_done = (clr_reg == AW'(SLOTS - 1));

    always_ff @(posedge clk)
    begin
        if (ctrl.pick)
        begin
            idx_reg  <= pick_idx;
            bad_reg  <= pick_bad;
            addr_reg <= pick_bad ? '0 : pick_idx[AW-1:0];
        end
    end

    // Bin memories.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [47:0]   ws_wdata, ws_rdata;
    logic [62:0]   sq_wdata, sq_rdata;
    logic [47:0]   ws_new;
    logic [62:0]   sq_new;

    assign ram_we   = ctrl.clr_step || (ctrl.update && cmd_reg == CMD_FILL);
    assign ram_addr = ctrl.clr_step ? clr_reg : (ctrl.pick ? pick_idx[AW-1:0] : addr_reg);
    assign ws_wdata = ctrl.clr_step ? '0 : ws_new;
    assign sq_wdata = ctrl.clr_step ? '0 : sq_new;

    wha_ram #(.WIDTH(48), .DEPTH(SLOTS)) u_ws_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ws_wdata),
        .rdata(ws_rdata)
    );

    wha_ram #(.WIDTH(63), .DEPTH(SLOTS)) u_sq_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(sq_wdata),
        .rdata(sq_rdata)
    );

    // Saturating sums for a fill; a read passes the stored values.
    logic [48:0] ws_sum;
    logic [63:0] sq_sum;
    logic [31:0] wsq;
    assign wsq    = 32'($signed(w_reg) * $signed(w_reg));
    assign ws_sum = {ws_rdata[47], ws_rdata} + {{33{w_reg[15]}}, w_reg};
    assign sq_sum = {1'b0, sq_rdata} + 64'(wsq);

    always_comb
    begin
        if (cmd_reg == CMD_FILL)
        begin
            if (ws_sum[48] != ws_sum[47])
            begin
                ws_new = ws_sum[48] ? WS_MIN : WS_MAX;
            end
            else
            begin
                ws_new = ws_sum[47:0];
            end
            sq_new = sq_sum[63] ? SQ_MAX : sq_sum[62:0];
        end
        else
        begin
            ws_new = ws_rdata;
            sq_new = sq_rdata;
        end
    end

    // Entry counter, saturating.
    logic [31:0] entries_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (ctrl.update && cmd_reg == CMD_FILL && entries_reg != '1)
        begin
            entries_reg <= entries_reg + 32'd1;
        end
    end

    // Result sum register.
    logic [47:0] ws_res_reg;
    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            ws_res_reg <= ws_new;
        end
    end

    // Bit-pair integer square root, one step per cycle.
    logic [62:0] x_reg, r_reg, bit_reg;
    logic [62:0] trial;
    assign trial         = r_reg + bit_reg;
    assign stat.sqrt_done = (bit_reg == '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.sqrt_go)
        begin
            x_reg   <= (bad_reg) ? '0 : sq_new;
            r_reg   <= '0;
            bit_reg <= 63'h4000_0000_0000_0000;
        end
        else if (ctrl.sqrt_step && !stat.sqrt_done)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Result fields.
    always_comb
    begin
        bin_index      = '0;
        weight_sum     = '0;
        error_estimate = '0;
        status         = 1'b0;
        entry_count    = entries_reg;
        case (cmd_reg)
            CMD_FILL:
            begin
                bin_index      = idx_reg;
                weight_sum     = ws_res_reg;
                error_estimate = r_reg[31:0];
            end
            CMD_READ:
            begin
                bin_index = idx_reg;
                status    = bad_reg;
                if (!bad_reg)
                begin
                    weight_sum     = ws_res_reg;
                    error_estimate = r_reg[31:0];
                end
            end
            CMD_CLEAR: ;
            default:   status = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[design/weighted_histogram_accumulator.sv]
// ----------------------------------------------------------------------------
// Weighted histogram accumulator
// Weighted one-dimensional histogram with underflow and overflow bins.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low, and its single
// result appears on the result ports for one cycle with done high; the
// receiver cannot stall. After reset the block stays busy while it zeroes the
// bin memories. A fill registers the scaling product, reads the bin memories
// and writes the updated sums back, runs the 32 steps of the shared bit-pair
// square-root unit, and then drives the result. A read skips the product. A
// clear sweeps all MAX_BINS+2 slots of the bin memories, one bin per cycle,
// and then drives the result. An unknown command gives its result in the
// cycle after acceptance. Busy falls in the cycle after the result.
// Configuration writes are accepted in any cycle but should only be made
// while busy is low.
`default_nettype none

module weighted_histogram_accumulator #(
    parameter int unsigned MAX_BINS = wha_pkg::MAX_BINS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] sample,
    input  wire logic [15:0] weight,
    input  wire logic [8:0]  bin_select,
    output logic             done,
    output logic [8:0]       bin_index,
    output logic [47:0]      weight_sum,
    output logic [31:0]      error_estimate,
    output logic [31:0]      entry_count,
    output logic             status
);
    import wha_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    wha_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .command(command),
        .stat   (stat),
        .busy   (busy),
        .ctrl   (ctrl),
        .done   (done)
    );

    wha_dp #(.MAX_BINS(MAX_BINS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .sample        (sample),
        .weight        (weight),
        .bin_select    (bin_select),
        .bin_index     (bin_index),
        .weight_sum    (weight_sum),
        .error_estimate(error_estimate),
        .entry_count   (entry_count),
        .status        (status)
    );

endmodule

`default_nettype wire

[design/wha_checker.sv]
// ----------------------------------------------------------------------------
// Weighted histogram checker
// Port-level assertions on the weighted histogram accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_histogram_accumulator_macros.svh"

module wha_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] entry_count
);

    // A result only ends a transaction in progress.
    `WHA_ASSERT(a_done_busy, !done || busy, "result outside a transaction")
    // An accepted transaction makes the block busy.
    `WHA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item not busy")
    // The entry count never falls.
    `WHA_ASSERT_NEXT(a_cnt_mono, 1'b1, entry_count >= $past(entry_count), "count fell")
    // The block is free after a result.
    `WHA_ASSERT_NEXT(a_done_free, done, !busy, "busy after result")

endmodule

bind weighted_histogram_accumulator wha_checker u_wha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .entry_count(entry_count)
);

`default_nettype wire
